// ----- rtl/tcpm_pkg.sv -----
// Shared widths, types and register codes for the triangle cutout pixel mask.
`default_nettype none

package tcpm_pkg;

	// Frame coordinate width and everything derived from it.
	localparam int COORD_BITS = 12;
	localparam int LOC_W      = COORD_BITS + 1;
	localparam int PROD_W     = 2 * COORD_BITS;
	localparam int EPROD_W    = 2 * LOC_W;
	localparam int EF_W       = 2 * COORD_BITS + 5;
	localparam int CHAN_W     = 8;
	localparam int CFG_IDX_W  = 3;

	typedef logic [COORD_BITS-1:0]     coord_t;
	typedef logic signed [LOC_W-1:0]   loc_t;
	typedef logic [PROD_W-1:0]         prod_t;
	typedef logic signed [EPROD_W-1:0] eprod_t;
	typedef logic signed [EF_W-1:0]    ef_t;
	typedef logic [CHAN_W-1:0]         chan_t;

	localparam chan_t CHAN_FULL  = 8'hFF;
	localparam chan_t CHAN_EMPTY = 8'h00;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VA_X = 3'd0,
		REG_VA_Y = 3'd1,
		REG_VB_X = 3'd2,
		REG_VB_Y = 3'd3,
		REG_VC_X = 3'd4,
		REG_VC_Y = 3'd5
	} cfg_reg_t;

endpackage

`default_nettype wire

// ----- rtl/triangle_cutout_pixel_mask_core.sv -----
// Top level of the triangle cutout pixel mask: vertex registers, coefficients and pixel pipeline.
// The pixel pipeline has six register ranks, the last one being the output register.
// Throughput: one pixel per cycle while out_stall is low; each rank advances when the next
// one is empty or moving.
// Triangle coefficients are rebuilt from the vertex registers through the coefficient ranks behind a write.
// Reset clears the vertex registers, the coefficients and all valid bits; no clearing pass.
`default_nettype none

module triangle_cutout_pixel_mask_core
	import tcpm_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire coord_t               cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire coord_t               pixel_x,
	input  wire coord_t               pixel_y,
	input  wire chan_t                byte_zero,
	input  wire chan_t                byte_one,
	input  wire chan_t                byte_two,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output loc_t                      local_x,
	output loc_t                      local_y,
	output logic                      inside_res,
	output chan_t                     chan_zero,
	output chan_t                     chan_one,
	output chan_t                     chan_two,
	output chan_t                     alpha
);

	function automatic coord_t min3(input coord_t a, input coord_t b, input coord_t c);
		coord_t m;
		m = a;
		if (b < m) m = b;
		if (c < m) m = c;
		return m;
	endfunction

	// Vertex registers.
	coord_t va_x_q, va_y_q, vb_x_q, vb_y_q, vc_x_q, vc_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_x_q <= '0;
			va_y_q <= '0;
			vb_x_q <= '0;
			vb_y_q <= '0;
			vc_x_q <= '0;
			vc_y_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_VA_X: va_x_q <= cfg_data;
				REG_VA_Y: va_y_q <= cfg_data;
				REG_VB_X: vb_x_q <= cfg_data;
				REG_VB_Y: vb_y_q <= cfg_data;
				REG_VC_X: vc_x_q <= cfg_data;
				REG_VC_Y: vc_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Bounding-box origin from the smallest vertex coordinates.
	coord_t ox_c, oy_c;

	always_comb begin
		ox_c = min3(va_x_q, vb_x_q, vc_x_q);
		oy_c = min3(va_y_q, vb_y_q, vc_y_q);
	end

	// Coefficient rank one: origin and vertices relative to it.
	coord_t ox_q, oy_q, ax_q, ay_q, bx_q, by_q, cx_q, cy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ox_q <= '0;
			oy_q <= '0;
			ax_q <= '0;
			ay_q <= '0;
			bx_q <= '0;
			by_q <= '0;
			cx_q <= '0;
			cy_q <= '0;
		end else begin
			ox_q <= ox_c;
			oy_q <= oy_c;
			ax_q <= va_x_q - ox_c;
			ay_q <= va_y_q - oy_c;
			bx_q <= vb_x_q - ox_c;
			by_q <= vb_y_q - oy_c;
			cx_q <= vc_x_q - ox_c;
			cy_q <= vc_y_q - oy_c;
		end
	end

	// Coefficient rank two: vertex cross products and the edge slopes.
	prod_t p_aycx_q, p_axcy_q, p_axby_q, p_aybx_q, p_bxcy_q, p_bycx_q;
	loc_t  v1_q, v2_q, v4_q, v5_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_aycx_q <= '0;
			p_axcy_q <= '0;
			p_axby_q <= '0;
			p_aybx_q <= '0;
			p_bxcy_q <= '0;
			p_bycx_q <= '0;
			v1_q     <= '0;
			v2_q     <= '0;
			v4_q     <= '0;
			v5_q     <= '0;
		end else begin
			p_aycx_q <= ay_q * cx_q;
			p_axcy_q <= ax_q * cy_q;
			p_axby_q <= ax_q * by_q;
			p_aybx_q <= ay_q * bx_q;
			p_bxcy_q <= bx_q * cy_q;
			p_bycx_q <= by_q * cx_q;
			v1_q     <= $signed({1'b0, cy_q}) - $signed({1'b0, ay_q});
			v2_q     <= $signed({1'b0, ax_q}) - $signed({1'b0, cx_q});
			v4_q     <= $signed({1'b0, ay_q}) - $signed({1'b0, by_q});
			v5_q     <= $signed({1'b0, bx_q}) - $signed({1'b0, ax_q});
		end
	end

	// Coefficient rank three: edge-function offsets and the signed twice-area.
	ef_t v0_q, v3_q, area_q;
	ef_t v0_c, v3_c;

	always_comb begin
		v0_c = ef_t'(p_aycx_q) - ef_t'(p_axcy_q);
		v3_c = ef_t'(p_axby_q) - ef_t'(p_aybx_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q   <= '0;
			v3_q   <= '0;
			area_q <= '0;
		end else begin
			v0_q   <= v0_c;
			v3_q   <= v3_c;
			area_q <= v0_c + v3_c + ef_t'(p_bxcy_q) - ef_t'(p_bycx_q);
		end
	end

	// Pipeline valid bits and the ready chain from the output back to the input.
	logic       vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic [6:1] stage_rdy;

	always_comb begin
		stage_rdy[6] = !vld_s6 || !out_stall;
		stage_rdy[5] = !vld_s5 || stage_rdy[6];
		stage_rdy[4] = !vld_s4 || stage_rdy[5];
		stage_rdy[3] = !vld_s3 || stage_rdy[4];
		stage_rdy[2] = !vld_s2 || stage_rdy[3];
		stage_rdy[1] = !vld_s1 || stage_rdy[2];
	end

	assign in_stall = !stage_rdy[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (stage_rdy[1]) vld_s1 <= in_valid;
			if (stage_rdy[2]) vld_s2 <= vld_s1;
			if (stage_rdy[3]) vld_s3 <= vld_s2;
			if (stage_rdy[4]) vld_s4 <= vld_s3;
			if (stage_rdy[5]) vld_s5 <= vld_s4;
			if (stage_rdy[6]) vld_s6 <= vld_s5;
		end
	end

	// Pixel payload through the pipeline.
	coord_t px_s1, py_s1, px_s2, py_s2;
	chan_t  b0_s1, b1_s1, b2_s1, b0_s2, b1_s2, b2_s2, b0_s3, b1_s3, b2_s3;
	chan_t  b0_s4, b1_s4, b2_s4, b0_s5, b1_s5, b2_s5;
	loc_t   lx_s3, ly_s3, lx_s4, ly_s4, lx_s5, ly_s5, lx_s6, ly_s6;
	eprod_t sx_s4, sy_s4, tx_s4, ty_s4;
	ef_t    s_s5, t_s5;
	logic   inside_s6;
	chan_t  c0_s6, c1_s6, c2_s6, alpha_s6;

	// Strict inside test, with the signs turned over for a negative area.
	ef_t  st_sum;
	logic area_neg, s_pos, t_pos, s_neg, t_neg, inside_c;

	always_comb begin
		st_sum   = s_s5 + t_s5;
		area_neg = area_q[EF_W-1];
		s_neg    = s_s5[EF_W-1];
		t_neg    = t_s5[EF_W-1];
		s_pos    = !s_neg && (|s_s5);
		t_pos    = !t_neg && (|t_s5);
		if (area_neg) begin
			inside_c = s_neg && t_neg && (st_sum > area_q);
		end else begin
			inside_c = s_pos && t_pos && (st_sum < area_q);
		end
	end

	always_ff @(posedge clk) begin
		// Rank one holds the request as taken.
		if (stage_rdy[1] && in_valid) begin
			px_s1 <= pixel_x;
			py_s1 <= pixel_y;
			b0_s1 <= byte_zero;
			b1_s1 <= byte_one;
			b2_s1 <= byte_two;
		end
		// Rank two gives the coefficients time to settle behind a vertex write.
		if (stage_rdy[2] && vld_s1) begin
			px_s2 <= px_s1;
			py_s2 <= py_s1;
			b0_s2 <= b0_s1;
			b1_s2 <= b1_s1;
			b2_s2 <= b2_s1;
		end
		// Position relative to the box origin.
		if (stage_rdy[3] && vld_s2) begin
			lx_s3 <= $signed({1'b0, px_s2}) - $signed({1'b0, ox_q});
			ly_s3 <= $signed({1'b0, py_s2}) - $signed({1'b0, oy_q});
			b0_s3 <= b0_s2;
			b1_s3 <= b1_s2;
			b2_s3 <= b2_s2;
		end
		// Slope terms of both edge functions.
		if (stage_rdy[4] && vld_s3) begin
			sx_s4 <= v1_q * lx_s3;
			sy_s4 <= v2_q * ly_s3;
			tx_s4 <= v4_q * lx_s3;
			ty_s4 <= v5_q * ly_s3;
			lx_s4 <= lx_s3;
			ly_s4 <= ly_s3;
			b0_s4 <= b0_s3;
			b1_s4 <= b1_s3;
			b2_s4 <= b2_s3;
		end
		// Edge function values.
		if (stage_rdy[5] && vld_s4) begin
			s_s5  <= v0_q + ef_t'(sx_s4) + ef_t'(sy_s4);
			t_s5  <= v3_q + ef_t'(tx_s4) + ef_t'(ty_s4);
			lx_s5 <= lx_s4;
			ly_s5 <= ly_s4;
			b0_s5 <= b0_s4;
			b1_s5 <= b1_s4;
			b2_s5 <= b2_s4;
		end
		// Output register: mask decision and channel reordering.
		if (stage_rdy[6] && vld_s5) begin
			lx_s6     <= lx_s5;
			ly_s6     <= ly_s5;
			inside_s6 <= inside_c;
			c0_s6     <= inside_c ? b1_s5 : CHAN_FULL;
			c1_s6     <= inside_c ? b2_s5 : CHAN_FULL;
			c2_s6     <= inside_c ? b0_s5 : CHAN_FULL;
			alpha_s6  <= inside_c ? CHAN_FULL : CHAN_EMPTY;
		end
	end

	assign out_valid  = vld_s6;
	assign local_x    = lx_s6;
	assign local_y    = ly_s6;
	assign inside_res = inside_s6;
	assign chan_zero  = c0_s6;
	assign chan_one   = c1_s6;
	assign chan_two   = c2_s6;
	assign alpha      = alpha_s6;

endmodule

`default_nettype wire

// ----- rtl/tcpm_checker.sv -----
// Port-level checker for the triangle cutout pixel mask, bound to the top level.
`default_nettype none

module tcpm_checker
	import tcpm_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_stall,
	input wire logic                 out_valid,
	input wire logic                 out_stall,
	input wire loc_t                 local_x,
	input wire loc_t                 local_y,
	input wire logic                 inside_res,
	input wire chan_t                chan_zero,
	input wire chan_t                chan_one,
	input wire chan_t                chan_two,
	input wire chan_t                alpha
);

	// No request taken and no output back-pressure in this cycle.
	logic quiet;
	assign quiet = !(in_valid && !in_stall) && !out_stall;

	// The input only stalls when the output is holding a result that is not taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while the output side is free");

	// A stalled result stays on the output unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(local_x) && $stable(local_y)
			&& $stable(inside_res) && $stable(chan_zero) && $stable(chan_one)
			&& $stable(chan_two) && $stable(alpha)))
		else $error("stalled result changed or vanished");

	// An inside pixel has non-negative local coordinates and is opaque; others are white and clear.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (inside_res
			? (alpha == CHAN_FULL && !local_x[LOC_W-1] && !local_y[LOC_W-1])
			: (alpha == CHAN_EMPTY && chan_zero == CHAN_FULL && chan_one == CHAN_FULL
				&& chan_two == CHAN_FULL)))
		else $error("mask output inconsistent with the inside flag");

	// Without new requests and without output back-pressure, the whole pipeline drains.
	assert property (@(posedge clk) disable iff (!arst_n)
		quiet ##1 quiet ##1 quiet ##1 quiet ##1 quiet ##1 quiet |=> !out_valid)
		else $error("result appeared without a matching request");

endmodule

bind triangle_cutout_pixel_mask_core tcpm_checker u_tcpm_checker (.*);

`default_nettype wire
